// ===== sv/fmr_pkg.sv =====
// ----------------------------------------------------------------------------
// fmr_pkg
// Types and constants shared by the framed message receiver modules.
// ----------------------------------------------------------------------------
package fmr_pkg;

    // sync pair and message ids
    localparam logic [7:0] SYNC_FIRST   = 8'hAA;
    localparam logic [7:0] SYNC_SECOND  = 8'h55;
    localparam logic [7:0] ID_HEARTBEAT = 8'h01;
    localparam logic [7:0] ID_TRACK     = 8'h02;

    // payload bytes kept per frame and the length a track needs
    localparam int unsigned KEEP_BYTES   = 6;
    localparam logic [7:0]  TRACK_LENGTH = 8'd6;
    localparam int unsigned KEEP_IDX_W   = $clog2(KEEP_BYTES);

    // kind of a reported frame
    typedef enum logic [1:0] {
        KIND_HEARTBEAT = 2'd0,
        KIND_TRACK     = 2'd1,
        KIND_OTHER     = 2'd2
    } frame_kind_t;

    // one received item
    typedef struct packed {
        logic [7:0] rx_byte;
    } rx_item_t;

    // one reported frame
    typedef struct packed {
        frame_kind_t        frame_kind;
        logic [7:0]         message_id;
        logic [7:0]         payload_length;
        logic [7:0]         alive_value;
        logic signed [15:0] track_dx;
        logic signed [15:0] track_dy;
        logic [15:0]        confidence_raw;
    } frame_item_t;

    // held input item as seen by the parser
    typedef struct packed {
        logic     valid;
        rx_item_t item;
    } rx_slot_t;

    // parser outcome for the held item
    typedef struct packed {
        logic        valid;
        frame_item_t item;
    } frame_slot_t;

endpackage

// ===== sv/fmr_stream_if.sv =====
// ----------------------------------------------------------------------------
// fmr_stream_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface fmr_stream_if #(
    parameter type item_t = logic [7:0]
);

    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ===== sv/fmr_input_stage.sv =====
// ----------------------------------------------------------------------------
// fmr_input_stage
// Input register: holds one received item until the parser takes it.
// ----------------------------------------------------------------------------
module fmr_input_stage (
    input  logic              clk,
    input  logic              rst_n,
    fmr_stream_if.sink        rx,
    input  logic              take,
    output fmr_pkg::rx_slot_t slot
);
    import fmr_pkg::*;

    logic     valid_reg;
    rx_item_t item_reg;

    // free when empty or being emptied this cycle
    assign rx.ready = !valid_reg || take;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            valid_reg <= rx.valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            item_reg <= rx.data;
        end
    end

    assign slot.valid = valid_reg;
    assign slot.item  = item_reg;

endmodule

// ===== sv/fmr_parser.sv =====
// ----------------------------------------------------------------------------
// fmr_parser
// Frame phase machine: sync hunt, header, payload capture and checksum.
// ----------------------------------------------------------------------------
module fmr_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fmr_pkg::rx_slot_t    slot,
    input  logic                 take,
    output fmr_pkg::frame_slot_t result
);
    import fmr_pkg::*;

    typedef enum logic [5:0] {
        PH_SYNC1 = 6'b000001,
        PH_SYNC2 = 6'b000010,
        PH_ID    = 6'b000100,
        PH_LEN   = 6'b001000,
        PH_DATA  = 6'b010000,
        PH_CHECK = 6'b100000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] id_reg, id_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] payload_reg [KEEP_BYTES];
    logic       store_en;
    logic [7:0] rx_b;
    logic [7:0] count_inc;

    assign rx_b      = slot.item.rx_byte;
    assign count_inc = count_reg + 8'd1;
    assign store_en  = (phase_reg == PH_DATA) && (count_reg < 8'(KEEP_BYTES));

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        id_next     = id_reg;
        length_next = length_reg;
        count_next  = count_reg;
        xor_next    = xor_reg;
        unique case (phase_reg)
            PH_SYNC2:
            begin
                phase_next = (rx_b == SYNC_SECOND) ? PH_ID : PH_SYNC1;
            end
            PH_ID:
            begin
                id_next    = rx_b;
                xor_next   = rx_b;
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                length_next = rx_b;
                xor_next    = xor_reg ^ rx_b;
                count_next  = 8'd0;
                phase_next  = (rx_b != 8'd0) ? PH_DATA : PH_CHECK;
            end
            PH_DATA:
            begin
                xor_next   = xor_reg ^ rx_b;
                count_next = count_inc;
                if (count_inc >= length_reg)
                begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK:
            begin
                phase_next = PH_SYNC1;
            end
            default:
            begin
                phase_next = (rx_b == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
            end
        endcase
    end

    // result for a good checksum
    always_comb
    begin
        result.valid = slot.valid && (phase_reg == PH_CHECK) && (rx_b == xor_reg);
        result.item.frame_kind     = KIND_OTHER;
        result.item.message_id     = id_reg;
        result.item.payload_length = length_reg;
        result.item.alive_value    = 8'd0;
        result.item.track_dx       = 16'sd0;
        result.item.track_dy       = 16'sd0;
        result.item.confidence_raw = 16'd0;
        priority if (id_reg == ID_HEARTBEAT && length_reg != 8'd0)
        begin
            result.item.frame_kind  = KIND_HEARTBEAT;
            result.item.alive_value = payload_reg[0];
        end
        else if (id_reg == ID_TRACK && length_reg >= TRACK_LENGTH)
        begin
            result.item.frame_kind     = KIND_TRACK;
            result.item.track_dx       = {payload_reg[0], payload_reg[1]};
            result.item.track_dy       = {payload_reg[2], payload_reg[3]};
            result.item.confidence_raw = {payload_reg[4], payload_reg[5]};
        end
    end

    // control and header registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SYNC1;
            id_reg     <= 8'd0;
            length_reg <= 8'd0;
            count_reg  <= 8'd0;
            xor_reg    <= 8'd0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            id_reg     <= id_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            xor_reg    <= xor_next;
        end
    end

    // first payload bytes of the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEEP_BYTES; i++)
            begin
                payload_reg[i] <= 8'd0;
            end
        end
        else if (take && store_en)
        begin
            payload_reg[count_reg[KEEP_IDX_W-1:0]] <= rx_b;
        end
    end

endmodule

// ===== sv/fmr_output_stage.sv =====
// ----------------------------------------------------------------------------
// fmr_output_stage
// Result register: holds one reported frame until the consumer takes it.
// ----------------------------------------------------------------------------
module fmr_output_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fmr_pkg::frame_slot_t result,
    output logic                 free,
    fmr_stream_if.source         frame
);
    import fmr_pkg::*;

    logic        valid_reg;
    frame_item_t item_reg;

    // can load when empty or being emptied this cycle
    assign free = !valid_reg || frame.ready;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= result.valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (free && result.valid)
        begin
            item_reg <= result.item;
        end
    end

    assign frame.valid = valid_reg;
    assign frame.data  = item_reg;

endmodule

// ===== sv/framed_message_receiver_top.sv =====
// ----------------------------------------------------------------------------
// framed_message_receiver_top
// Byte-serial frame receiver with sync pair, length and XOR checksum.
//
//   channel  direction  payload        handshake
//   rx       in         rx_item_t      valid/ready, one byte per item
//   frame    out        frame_item_t   valid/ready, one item per good frame
//
// One byte per cycle sustained while the frame channel is not stalled; a good
// frame is offered once its checksum byte has passed the input register and
// the result register has loaded it.
// Reset puts the parser in sync hunt with all header fields cleared.
// A stalled frame channel holds the parser; the input register still takes
// one byte while the parser waits.
// ----------------------------------------------------------------------------
module framed_message_receiver_top (
    input  logic         clk,
    input  logic         rst_n,
    fmr_stream_if.sink   rx,
    fmr_stream_if.source frame
);
    import fmr_pkg::*;

    rx_slot_t    slot;
    frame_slot_t result;
    logic        out_free;
    logic        take;

    // parser moves on when a byte is held and the result register can load
    assign take = slot.valid && out_free;

    fmr_input_stage u_input (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .take  (take),
        .slot  (slot)
    );

    fmr_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .slot   (slot),
        .take   (take),
        .result (result)
    );

    fmr_output_stage u_output (
        .clk    (clk),
        .rst_n  (rst_n),
        .result (result),
        .free   (out_free),
        .frame  (frame)
    );

endmodule
